// ----- hdl/qefc_pkg.sv -----
// Package with the shared widths, reset value and default filter lengths of the QRS energy chain.
`default_nettype none

package qefc_pkg;

    // Fixed field widths of the ports.
    localparam int SAMPLE_W = 16;
    localparam int ENERGY_W = 16;
    localparam int LIMIT_W  = 16;

    // Saturation ceiling after reset.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd32000;

    // Default filter lengths.
    localparam int LP_LENGTH_DEF     = 10;
    localparam int HP_LENGTH_DEF     = 25;
    localparam int DERIV_DELAY_DEF   = 2;
    localparam int WINDOW_LENGTH_DEF = 16;

endpackage : qefc_pkg

`default_nettype wire

// ----- hdl/qrs_energy_filter_chain_unit.sv -----
// QRS energy filter chain: low-pass, high-pass, slope, magnitude and moving-window average.
// Each sample passes through the input, low-pass, high-pass, window and output registers in turn.
// Throughput: one sample per cycle; five register stages each take a new sample
// whenever the stage after them is empty or is handing its content on.
// Each constant division is a reciprocal multiply read straight from a stage register.
// Reset (synchronous, active low) clears every delay line, sum and valid bit and
// loads the output limit with 32000; the chain accepts samples in the next cycle.
`default_nettype none

module qrs_energy_filter_chain_unit
    import qefc_pkg::*;
#(
    parameter int LP_LENGTH     = LP_LENGTH_DEF,
    parameter int HP_LENGTH     = HP_LENGTH_DEF,
    parameter int DERIV_DELAY   = DERIV_DELAY_DEF,
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Configuration write port for the output limit.
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [LIMIT_W-1:0]         i_cfg_wr_data,
    // Sample channel.
    input  wire logic                       i_sample_valid,
    output logic                            o_sample_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    // Energy channel.
    output logic                            o_energy_valid,
    input  wire logic                       i_energy_ready,
    output logic [ENERGY_W-1:0]             o_energy
);

    // Derived lengths and widths.
    localparam int LP_HALF = LP_LENGTH / 2;
    localparam int LP_DIV  = (LP_LENGTH * LP_LENGTH) / 4;
    localparam int LP_W    = SAMPLE_W + 2 * $clog2(LP_HALF + 1) + 2;
    localparam int Q_W     = SAMPLE_W + 1;
    localparam int HS_W    = Q_W + $clog2(HP_LENGTH) + 1;
    localparam int Z_W     = SAMPLE_W + 2;
    localparam int D_W     = Z_W + 1;
    localparam int A_W     = D_W;
    localparam int WS_W    = A_W + $clog2(WINDOW_LENGTH);

    // Reciprocal constants: floor(m / D) = (m * ceil(2^S / D)) >> S for every
    // m below 2^N when S = N + ceil(log2 D).
    localparam int LP_SH = LP_W + $clog2(LP_DIV);
    localparam int LP_MW = LP_W + 1;
    localparam logic [LP_MW-1:0] LP_MUL =
        LP_MW'(((64'd1 << LP_SH) + 64'(LP_DIV) - 64'd1) / 64'(LP_DIV));

    localparam int HP_SH = HS_W + $clog2(HP_LENGTH);
    localparam int HP_MW = HS_W + 1;
    localparam logic [HP_MW-1:0] HP_MUL =
        HP_MW'(((64'd1 << HP_SH) + 64'(HP_LENGTH) - 64'd1) / 64'(HP_LENGTH));

    localparam int W_SH = WS_W + $clog2(WINDOW_LENGTH);
    localparam int W_MW = WS_W + 1;
    localparam logic [W_MW-1:0] W_MUL =
        W_MW'(((64'd1 << W_SH) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

    // Configuration register.
    logic [LIMIT_W-1:0] r_output_limit;

    // Stage 1: input register.
    logic                       r_v1;
    logic signed [SAMPLE_W-1:0] r_x;

    // Stage 2: low-pass output (also the recursion state) and its delay lines.
    logic                       r_v2;
    logic signed [LP_W-1:0]     r_lp_y;
    logic signed [LP_W-1:0]     r_lp_y2;
    logic signed [SAMPLE_W-1:0] r_lp_hist [LP_LENGTH];

    // Stage 3: high-pass running sum, center tap and delay line.
    logic                       r_v3;
    logic signed [HS_W-1:0]     r_hp_sum;
    logic signed [Q_W-1:0]      r_hp_mid;
    logic signed [Q_W-1:0]      r_hp_hist [HP_LENGTH];

    // Stage 4: window sum, slope and window delay lines.
    logic                       r_v4;
    logic [WS_W-1:0]            r_w_sum;
    logic signed [Z_W-1:0]      r_sl_hist [DERIV_DELAY];
    logic [A_W-1:0]             r_w_hist [WINDOW_LENGTH];

    // Stage 5: output register.
    logic                       r_v5;
    logic [ENERGY_W-1:0]        r_energy;

    // Flow control: a stage loads when it is empty or its content moves on.
    logic load1, load2, load3, load4, load5;
    logic free1, free2, free3, free4, free5;

    assign free5 = !r_v5 || i_energy_ready;
    assign load5 = r_v4 && free5;
    assign free4 = !r_v4 || load5;
    assign load4 = r_v3 && free4;
    assign free3 = !r_v3 || load4;
    assign load3 = r_v2 && free3;
    assign free2 = !r_v2 || load3;
    assign load2 = r_v1 && free2;
    assign free1 = !r_v1 || load2;
    assign load1 = i_sample_valid && free1;

    assign o_sample_ready = free1;
    assign o_energy_valid = r_v5;
    assign o_energy       = r_energy;

    // Low-pass recursion: y = 2*y1 - y2 + x - 2*x[n-L/2] + x[n-L].
    logic signed [LP_W-1:0] n_lp_y;
    logic signed [LP_W-1:0] lp_x_ext;
    logic signed [LP_W-1:0] lp_mid_ext;
    logic signed [LP_W-1:0] lp_old_ext;

    assign lp_x_ext   = LP_W'(r_x);
    assign lp_mid_ext = LP_W'(r_lp_hist[LP_HALF-1]);
    assign lp_old_ext = LP_W'(r_lp_hist[LP_LENGTH-1]);
    assign n_lp_y     = (r_lp_y <<< 1) - r_lp_y2 + lp_x_ext - (lp_mid_ext <<< 1) + lp_old_ext;

    // Low-pass scaling: divide by L*L/4, truncating toward zero.
    logic                      lp_neg;
    logic [LP_W-1:0]           lp_mag;
    logic [LP_W+LP_MW-1:0]     lp_prod;
    logic [Q_W-1:0]            lp_qm;
    logic signed [Q_W-1:0]     lp_q;

    assign lp_neg  = r_lp_y[LP_W-1];
    assign lp_mag  = lp_neg ? unsigned'(-r_lp_y) : unsigned'(r_lp_y);
    assign lp_prod = lp_mag * LP_MUL;
    assign lp_qm   = Q_W'(lp_prod >> LP_SH);
    assign lp_q    = lp_neg ? -$signed(lp_qm) : $signed(lp_qm);

    // High-pass running sum update.
    logic signed [HS_W-1:0] n_hp_sum;

    assign n_hp_sum = r_hp_sum + HS_W'(lp_q) - HS_W'(r_hp_hist[HP_LENGTH-1]);

    // High-pass mean: running sum divided by its length, truncating toward zero.
    logic                      hp_neg;
    logic [HS_W-1:0]           hp_mag;
    logic [HS_W+HP_MW-1:0]     hp_prod;
    logic [Q_W-1:0]            hp_qm;
    logic signed [Q_W-1:0]     hp_q;

    assign hp_neg  = r_hp_sum[HS_W-1];
    assign hp_mag  = hp_neg ? unsigned'(-r_hp_sum) : unsigned'(r_hp_sum);
    assign hp_prod = hp_mag * HP_MUL;
    assign hp_qm   = Q_W'(hp_prod >> HP_SH);
    assign hp_q    = hp_neg ? -$signed(hp_qm) : $signed(hp_qm);

    // High-pass output, slope and its magnitude.
    logic signed [Z_W-1:0] hp_z;
    logic signed [D_W-1:0] slope_d;
    logic [A_W-1:0]        slope_abs;

    assign hp_z      = Z_W'(r_hp_mid) - Z_W'(hp_q);
    assign slope_d   = D_W'(hp_z) - D_W'(r_sl_hist[DERIV_DELAY-1]);
    assign slope_abs = slope_d[D_W-1] ? unsigned'(-slope_d) : unsigned'(slope_d);

    // Moving-window sum update.
    logic [WS_W-1:0] n_w_sum;

    assign n_w_sum = r_w_sum + WS_W'(slope_abs) - WS_W'(r_w_hist[WINDOW_LENGTH-1]);

    // Window average and saturation at the configured limit.
    logic [WS_W+W_MW-1:0] w_prod;
    logic [A_W-1:0]       w_avg;
    logic [ENERGY_W-1:0]  n_energy;

    assign w_prod   = r_w_sum * W_MUL;
    assign w_avg    = A_W'(w_prod >> W_SH);
    assign n_energy = (w_avg > A_W'(r_output_limit)) ? r_output_limit : w_avg[ENERGY_W-1:0];

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_output_limit <= i_cfg_wr_data;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (load1) begin
                r_v1 <= 1'b1;
            end else if (load2) begin
                r_v1 <= 1'b0;
            end
            if (load2) begin
                r_v2 <= 1'b1;
            end else if (load3) begin
                r_v2 <= 1'b0;
            end
            if (load3) begin
                r_v3 <= 1'b1;
            end else if (load4) begin
                r_v3 <= 1'b0;
            end
            if (load4) begin
                r_v4 <= 1'b1;
            end else if (load5) begin
                r_v4 <= 1'b0;
            end
            if (load5) begin
                r_v5 <= 1'b1;
            end else if (i_energy_ready) begin
                r_v5 <= 1'b0;
            end
        end
    end

    // Input register and output register carry payload only.
    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_x <= i_sample;
        end
        if (load5) begin
            r_energy <= n_energy;
        end
    end

    // Low-pass state: output history and the sample delay line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_y  <= '0;
            r_lp_y2 <= '0;
            for (int k = 0; k < LP_LENGTH; k++) begin
                r_lp_hist[k] <= '0;
            end
        end else if (load2) begin
            r_lp_y  <= n_lp_y;
            r_lp_y2 <= r_lp_y;
            r_lp_hist[0] <= r_x;
            for (int k = 1; k < LP_LENGTH; k++) begin
                r_lp_hist[k] <= r_lp_hist[k-1];
            end
        end
    end

    // High-pass state: running sum, center tap and delay line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_sum <= '0;
            r_hp_mid <= '0;
            for (int k = 0; k < HP_LENGTH; k++) begin
                r_hp_hist[k] <= '0;
            end
        end else if (load3) begin
            r_hp_sum <= n_hp_sum;
            r_hp_mid <= r_hp_hist[LP_HALF == 0 ? 0 : HP_LENGTH/2-1];
            r_hp_hist[0] <= lp_q;
            for (int k = 1; k < HP_LENGTH; k++) begin
                r_hp_hist[k] <= r_hp_hist[k-1];
            end
        end
    end

    // Slope and window state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_sum <= '0;
            for (int k = 0; k < DERIV_DELAY; k++) begin
                r_sl_hist[k] <= '0;
            end
            for (int k = 0; k < WINDOW_LENGTH; k++) begin
                r_w_hist[k] <= '0;
            end
        end else if (load4) begin
            r_w_sum <= n_w_sum;
            r_sl_hist[0] <= hp_z;
            for (int k = 1; k < DERIV_DELAY; k++) begin
                r_sl_hist[k] <= r_sl_hist[k-1];
            end
            r_w_hist[0] <= slope_abs;
            for (int k = 1; k < WINDOW_LENGTH; k++) begin
                r_w_hist[k] <= r_w_hist[k-1];
            end
        end
    end

    // An accepted sample always lands in the input register.
    a_accept_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_valid && o_sample_ready) |=> r_v1)
        else $error("accepted sample did not reach the input register");

    // A held low-pass result keeps its value until stage three takes it.
    a_lp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !load3) |=> (r_v2 && $stable(r_lp_y)))
        else $error("low-pass stage changed while stalled");

    // A held window sum keeps its value until the output register takes it.
    a_window_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !load5) |=> (r_v4 && $stable(r_w_sum)))
        else $error("window stage changed while stalled");

    // A loaded energy value never exceeds the limit in force when it was computed.
    a_energy_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load5 |=> (r_energy <= $past(r_output_limit)))
        else $error("energy exceeds the output limit");

endmodule : qrs_energy_filter_chain_unit

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the QRS energy filter chain unit.
module tb;
    import qefc_pkg::*;

    localparam int LP_LEN      = LP_LENGTH_DEF;
    localparam int HP_LEN      = HP_LENGTH_DEF;
    localparam int SLOPE_LEN   = DERIV_DELAY_DEF;
    localparam int WIN_LEN     = WINDOW_LENGTH_DEF;
    localparam int CYCLE_LIMIT = 500000;

    typedef enum int {
        SHAPE_NOISE,
        SHAPE_BEATS,
        SHAPE_SQUARE,
        SHAPE_RAMP
    } t_shape;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_wr_en    = 1'b0;
    logic [LIMIT_W-1:0]          cfg_wr_data  = '0;
    logic                        sample_valid = 1'b0;
    logic signed [SAMPLE_W-1:0]  sample       = '0;
    logic                        energy_ready = 1'b0;
    logic                        o_sample_ready;
    logic                        o_energy_valid;
    logic [ENERGY_W-1:0]         o_energy;

    logic signed [SAMPLE_W-1:0]  pending_samples[$];
    logic [ENERGY_W-1:0]         energy_due[$];
    logic                        sample_taken = 1'b0;
    int                          error_count  = 0;
    int                          cycle_count  = 0;
    int                          send_gap     = 0;
    int                          send_calm    = 0;
    int                          stall_left   = 0;
    int                          recv_calm    = 0;

    // Predictor state: delay lines, sums and the output ceiling.
    longint                      lowpass_taps[LP_LEN];
    longint                      lowpass_y1;
    longint                      lowpass_y2;
    int                          lowpass_pos;
    longint                      highpass_taps[HP_LEN];
    longint                      highpass_sum;
    int                          highpass_pos;
    longint                      slope_taps[SLOPE_LEN];
    int                          slope_pos;
    longint                      window_taps[WIN_LEN];
    longint                      window_sum;
    int                          window_pos;
    logic [LIMIT_W-1:0]          energy_ceiling;

    qrs_energy_filter_chain_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_sample_valid (sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (sample),
        .o_energy_valid (o_energy_valid),
        .i_energy_ready (energy_ready),
        .o_energy       (o_energy)
    );

    always #2 clk = ~clk;

    // Runs one sample through the whole chain and returns the expected energy.
    function automatic logic [ENERGY_W-1:0] predict_energy(logic signed [SAMPLE_W-1:0] raw);
        longint x;
        longint y;
        longint z;
        longint d;
        longint mag;
        longint avg;
        int     half;
        x = raw;

        // Recursive low-pass, scaled down by the square of half its length.
        half = (lowpass_pos >= LP_LEN / 2) ? lowpass_pos - LP_LEN / 2
                                           : lowpass_pos + LP_LEN - LP_LEN / 2;
        y = 2 * lowpass_y1 - lowpass_y2 + x - 2 * lowpass_taps[half] + lowpass_taps[lowpass_pos];
        lowpass_y2 = lowpass_y1;
        lowpass_y1 = y;
        lowpass_taps[lowpass_pos] = x;
        lowpass_pos = (lowpass_pos + 1 >= LP_LEN) ? 0 : lowpass_pos + 1;
        y = y / ((LP_LEN * LP_LEN) / 4);

        // Running-sum high-pass: delayed center sample minus the mean.
        highpass_sum = highpass_sum + y - highpass_taps[highpass_pos];
        half = (highpass_pos >= HP_LEN / 2) ? highpass_pos - HP_LEN / 2
                                            : highpass_pos + HP_LEN - HP_LEN / 2;
        z = highpass_taps[half] - highpass_sum / HP_LEN;
        highpass_taps[highpass_pos] = y;
        highpass_pos = (highpass_pos + 1 >= HP_LEN) ? 0 : highpass_pos + 1;

        // Slope against the value a few samples back, then its magnitude.
        d = z - slope_taps[slope_pos];
        slope_taps[slope_pos] = z;
        slope_pos = (slope_pos + 1 >= SLOPE_LEN) ? 0 : slope_pos + 1;
        mag = (d < 0) ? -d : d;

        // Moving-window average, clamped to the ceiling.
        window_sum = window_sum + mag - window_taps[window_pos];
        window_taps[window_pos] = mag;
        window_pos = (window_pos + 1 >= WIN_LEN) ? 0 : window_pos + 1;
        avg = window_sum / WIN_LEN;
        if (avg < 0) return '0;
        if (avg > $signed({48'd0, energy_ceiling})) return energy_ceiling;
        return avg[ENERGY_W-1:0];
    endfunction

    // Mostly short gaps, a few long ones; none during a calm stretch.
    function automatic int idle_length(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] to_sample(int v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[SAMPLE_W-1:0];
    endfunction

    // Fills the sample queue with ECG-like segments and some plain noise.
    task automatic queue_signal(int count);
        int     made;
        int     len;
        int     k;
        int     roll;
        int     base;
        int     amp;
        int     period;
        int     half_len;
        int     step;
        int     level;
        int     beat_pos;
        int     val;
        t_shape shape;
        made = 0;
        while (made < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) shape = SHAPE_NOISE;
            else if (roll < 50) shape = SHAPE_BEATS;
            else if (roll < 75) shape = SHAPE_SQUARE;
            else shape = SHAPE_RAMP;
            len = $urandom_range(20, 90);
            if (len > count - made) len = count - made;
            base = int'($urandom_range(0, 8000)) - 4000;
            amp = $urandom_range(200, 32767);
            period = $urandom_range(12, 80);
            half_len = $urandom_range(1, 24);
            step = int'($urandom_range(0, 1200)) - 600;
            level = base;
            for (k = 0; k < len; k++) begin
                case (shape)
                    SHAPE_NOISE: begin
                        val = int'($urandom_range(0, 65535)) - 32768;
                    end
                    SHAPE_BEATS: begin
                        // Sharp rise, fall and small undershoot, then a noisy baseline.
                        beat_pos = k % period;
                        if (beat_pos < 3) val = base + amp * (beat_pos + 1) / 3;
                        else if (beat_pos < 6) val = base + amp * (5 - beat_pos) / 3 - amp / 4;
                        else val = base + int'($urandom_range(0, 400)) - 200;
                    end
                    SHAPE_SQUARE: begin
                        val = ((k / half_len) % 2 != 0) ? base - amp : base + amp;
                    end
                    default: begin
                        // Slow drift that turns around at the rails.
                        level = level + step;
                        if (level > 32767 || level < -32768) step = -step;
                        val = level + int'($urandom_range(0, 100)) - 50;
                    end
                endcase
                pending_samples.push_back(to_sample(val));
            end
            made += len;
        end
    endtask

    // Waits until every sample is sent and every energy value has come back.
    task automatic settle_idle();
        while (pending_samples.size() != 0 || sample_valid || energy_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        energy_ceiling = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sample driver: presents queued samples with random gaps between transactions.
    always @(negedge clk) begin
        if (rst_n && (!sample_valid || sample_taken)) begin
            if (send_calm > 0) send_calm--;
            else if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(40, 150);
            if (send_gap > 0 || pending_samples.size() == 0) begin
                if (send_gap > 0) send_gap--;
                sample_valid <= 1'b0;
            end else begin
                sample_valid <= 1'b1;
                sample <= pending_samples.pop_front();
                send_gap = idle_length(send_calm > 0);
            end
        end
    end

    // Energy receiver: random stalls on the ready line.
    always @(negedge clk) begin
        if (rst_n) begin
            if (recv_calm > 0) recv_calm--;
            else if ($urandom_range(0, 99) < 3) recv_calm = $urandom_range(40, 150);
            if (stall_left > 0) begin
                stall_left--;
                energy_ready <= 1'b0;
            end else begin
                energy_ready <= 1'b1;
                stall_left = idle_length(recv_calm > 0);
            end
        end
    end

    // Monitor: predicts on each sample transaction and checks each energy transaction.
    always @(posedge clk) begin
        logic [ENERGY_W-1:0] want;
        if (rst_n) begin
            if (sample_valid && o_sample_ready) energy_due.push_back(predict_energy(sample));
            if (o_energy_valid && energy_ready) begin
                if (energy_due.size() == 0) begin
                    $display("%0t: energy expected none, actual %0d", $time, o_energy);
                    error_count++;
                end else begin
                    want = energy_due.pop_front();
                    if (o_energy !== want) begin
                        $display("%0t: energy expected %0d, actual %0d", $time, want, o_energy);
                        error_count++;
                    end
                end
            end
        end
        sample_taken <= sample_valid && o_sample_ready;
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Reset, directed samples, then random signal phases under several ceilings.
    initial begin
        int                 phase;
        logic [LIMIT_W-1:0] ceiling;
        foreach (lowpass_taps[i]) lowpass_taps[i] = 0;
        foreach (highpass_taps[i]) highpass_taps[i] = 0;
        foreach (slope_taps[i]) slope_taps[i] = 0;
        foreach (window_taps[i]) window_taps[i] = 0;
        lowpass_y1 = 0;
        lowpass_y2 = 0;
        lowpass_pos = 0;
        highpass_sum = 0;
        highpass_pos = 0;
        slope_pos = 0;
        window_sum = 0;
        window_pos = 0;
        energy_ceiling = LIMIT_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero, held rails, full-scale toggling and bit patterns,
        // under the ceiling loaded by reset.
        pending_samples.push_back(16'sd0);
        repeat (4) pending_samples.push_back(16'sh7FFF);
        repeat (4) pending_samples.push_back(16'sh8000);
        repeat (4) begin
            pending_samples.push_back(16'sh7FFF);
            pending_samples.push_back(16'sh8000);
        end
        pending_samples.push_back(16'shFFFF);
        pending_samples.push_back(16'sd1);
        pending_samples.push_back(16'sh5555);
        pending_samples.push_back(16'shAAAA);
        pending_samples.push_back(16'sd0);
        pending_samples.push_back(16'sd0);
        settle_idle();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: ceiling = '0;
                1: ceiling = '1;
                2: ceiling = LIMIT_W'($urandom_range(1, 400));
                3: ceiling = LIMIT_W'($urandom_range(0, 65535));
                4: ceiling = LIMIT_RESET;
                default: ceiling = LIMIT_W'($urandom_range(400, 3000));
            endcase
            write_limit(ceiling);
            queue_signal(280);
            settle_idle();
        end

        if (error_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
